>>> hw/rtl/fat16_volume_geometry_core_defines.svh
// assertion macros used by the geometry core port checker
`ifndef FAT16_VOLUME_GEOMETRY_CORE_DEFINES_SVH
`define FAT16_VOLUME_GEOMETRY_CORE_DEFINES_SVH

// same-cycle implication, checked at every rising clock outside reset
`define FGEO_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked at every rising clock outside reset
`define FGEO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/fat_geo_pkg.sv
// types, constants and stage functions of the fat16 volume geometry core
package fat_geo_pkg;

   // result codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FAT_ZERO  = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_DIV_ZERO  = 2'd3;

   localparam logic [31:0] MIN_CLUSTERS = 32'd4085;
   localparam logic [31:0] MAX_CLUSTERS = 32'd65524;
   localparam int          ENTRY_SHIFT  = 5;    // 32 bytes per root entry

   // quotient bits of the root sector divide and of the cluster divide
   localparam int DIV1_BITS   = 22;
   localparam int DIV2_BITS   = 32;
   localparam int MID_STAGE   = DIV1_BITS + 1;
   localparam int PIPE_STAGES = MID_STAGE + DIV2_BITS + 1;

   typedef struct packed {
      logic [15:0] bytes_per_sector;
      logic [7:0]  sectors_per_cluster;
      logic [15:0] reserved_sectors;
      logic [7:0]  fat_copies;
      logic [15:0] root_entries;
      logic [15:0] total_sectors_short;
      logic [31:0] total_sectors_long;
      logic [15:0] fat_sectors;
   } geo_req_type;

   typedef struct packed {
      logic [31:0] fat_offset;
      logic [31:0] root_offset;
      logic [31:0] data_offset;
      logic [31:0] cluster_count;
      logic [1:0]  status;
      logic        fat_count_warning;
   } geo_rsp_type;

   // state carried by every pipeline stage
   typedef struct packed {
      logic [15:0] bps;
      logic [7:0]  spc;
      logic [15:0] rsvd;
      logic [23:0] fat_prod;
      logic [31:0] total;
      logic        fsz_zero;
      logic        nfat_warn;
      logic [31:0] fat_off;
      logic [31:0] root_off;
      logic [31:0] root_bytes;
      logic [31:0] dq;     // dividend shifting out, quotient shifting in
      logic [15:0] rem;
   } geo_pipe_type;

   // entry stage: operand capture, first products, root dividend
   function automatic geo_pipe_type geo_entry(geo_req_type r);
      geo_pipe_type n;
      logic [21:0]  num;
      n            = '0;
      num          = {1'b0, r.root_entries, {ENTRY_SHIFT{1'b0}}}
                     + {6'b0, r.bytes_per_sector} - 22'd1;
      n.bps        = r.bytes_per_sector;
      n.spc        = r.sectors_per_cluster;
      n.rsvd       = r.reserved_sectors;
      n.fat_prod   = 24'(r.fat_copies * r.fat_sectors);
      n.total      = (r.total_sectors_long != 32'd0) ? r.total_sectors_long
                                                     : {16'b0, r.total_sectors_short};
      n.fsz_zero   = (r.fat_sectors == 16'd0);
      n.nfat_warn  = (r.fat_copies != 8'd1);
      n.fat_off    = 32'(r.bytes_per_sector * r.reserved_sectors);
      n.dq         = {10'b0, num};
      n.rem        = 16'd0;
      return n;
   endfunction

   // one restoring step of the root sector divide by sector size
   function automatic geo_pipe_type geo_div1_step(geo_pipe_type p);
      geo_pipe_type n;
      logic [16:0]  trial;
      logic         ge;
      n     = p;
      trial = {p.rem, p.dq[DIV1_BITS-1]};
      ge    = (trial >= {1'b0, p.bps});
      n.rem = ge ? 16'(trial - {1'b0, p.bps}) : trial[15:0];
      n.dq  = {10'b0, p.dq[DIV1_BITS-2:0], ge};
      return n;
   endfunction

   // middle stage: root region bytes and sectors left for clusters
   function automatic geo_pipe_type geo_mid(geo_pipe_type p);
      geo_pipe_type n;
      logic [15:0]  root_sec;
      logic [31:0]  overhead;
      n            = p;
      root_sec     = p.dq[15:0];
      n.root_bytes = 32'(p.bps * root_sec);
      overhead     = {16'b0, p.rsvd} + {8'b0, p.fat_prod} + {16'b0, root_sec};
      n.dq         = p.total - overhead;
      n.rem        = 16'd0;
      return n;
   endfunction

   // one restoring step of the cluster divide by cluster size
   function automatic geo_pipe_type geo_div2_step(geo_pipe_type p);
      geo_pipe_type n;
      logic [8:0]   trial;
      logic         ge;
      n     = p;
      trial = {p.rem[7:0], p.dq[DIV2_BITS-1]};
      ge    = (trial >= {1'b0, p.spc});
      n.rem = {8'b0, (ge ? 8'(trial - {1'b0, p.spc}) : trial[7:0])};
      n.dq  = {p.dq[DIV2_BITS-2:0], ge};
      return n;
   endfunction

   // last stage: checks in priority order, offsets only when valid
   function automatic geo_rsp_type geo_finish(geo_pipe_type p);
      geo_rsp_type r;
      r                   = '0;
      r.fat_count_warning = p.nfat_warn;
      if (p.fsz_zero) begin
         r.status = ST_FAT_ZERO;
      end else if (p.bps == 16'd0 || p.spc == 8'd0) begin
         r.status = ST_DIV_ZERO;
      end else if (p.dq < MIN_CLUSTERS || p.dq > MAX_CLUSTERS) begin
         r.status        = ST_RANGE;
         r.cluster_count = p.dq;
      end else begin
         r.status        = ST_OK;
         r.cluster_count = p.dq;
         r.fat_offset    = p.fat_off;
         r.root_offset   = p.root_off;
         r.data_offset   = p.root_off + p.root_bytes;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/fat16_volume_geometry_core.sv
// fat16 volume geometry: boot parameter block fields in, region offsets out
// throughput: one transaction per cycle while the output does not stall; two
// bit-per-stage dividers (22 + 32 stages) set the depth, every stage registered
// with its own valid bit
// a stalled output backs up only the occupied stages, bubbles still close up
// reset clears all valid bits; payload registers are not reset
module fat16_volume_geometry_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fat_geo_pkg::geo_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output fat_geo_pkg::geo_rsp_type rsp_data
);

   localparam int NSTG = fat_geo_pkg::PIPE_STAGES;

   fat_geo_pkg::geo_pipe_type pipe_ff [0:NSTG-1];
   fat_geo_pkg::geo_pipe_type pipe_in [0:NSTG-1];
   logic [NSTG-1:0]           valid_ff;
   logic [NSTG:0]             load;
   fat_geo_pkg::geo_rsp_type  rsp_ff;
   fat_geo_pkg::geo_rsp_type  rsp_in;
   logic                      rsp_valid_ff;

   // a stage loads when empty or when its successor loads
   assign load[NSTG] = !rsp_valid_ff || !rsp_stall;
   generate
      for (genvar k = 0; k < NSTG; k++) begin : g_load
         assign load[k] = !valid_ff[k] || load[k+1];
      end
   endgenerate

   assign req_stall = !load[0];

   // next value of each stage
   generate
      for (genvar k = 0; k < NSTG; k++) begin : g_stage
         if (k == 0) begin : g_entry
            always_comb begin
               pipe_in[k] = fat_geo_pkg::geo_entry(req_data);
            end
         end else if (k == 1) begin : g_div1_mul
            // first divide step also forms the fat region bytes
            logic [39:0] fat_bytes;
            always_comb begin
               fat_bytes          = pipe_ff[k-1].bps * pipe_ff[k-1].fat_prod;
               pipe_in[k]          = fat_geo_pkg::geo_div1_step(pipe_ff[k-1]);
               pipe_in[k].root_off = fat_bytes[31:0];
            end
         end else if (k == 2) begin : g_div1_add
            always_comb begin
               pipe_in[k]          = fat_geo_pkg::geo_div1_step(pipe_ff[k-1]);
               pipe_in[k].root_off = pipe_ff[k-1].fat_off + pipe_ff[k-1].root_off;
            end
         end else if (k <= fat_geo_pkg::DIV1_BITS) begin : g_div1
            always_comb begin
               pipe_in[k] = fat_geo_pkg::geo_div1_step(pipe_ff[k-1]);
            end
         end else if (k == fat_geo_pkg::MID_STAGE) begin : g_mid
            always_comb begin
               pipe_in[k] = fat_geo_pkg::geo_mid(pipe_ff[k-1]);
            end
         end else begin : g_div2
            always_comb begin
               pipe_in[k] = fat_geo_pkg::geo_div2_step(pipe_ff[k-1]);
            end
         end
      end
   endgenerate

   always_comb begin
      rsp_in = fat_geo_pkg::geo_finish(pipe_ff[NSTG-1]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (load[i]) begin
               valid_ff[i] <= (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i-1];
            end
         end
         if (load[NSTG]) begin
            rsp_valid_ff <= valid_ff[NSTG-1];
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (load[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
      if (load[NSTG]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/fat_geo_chk.sv
// port checker for the fat16 volume geometry core, bound to the top level
`include "fat16_volume_geometry_core_defines.svh"

module fat_geo_chk (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input fat_geo_pkg::geo_req_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input fat_geo_pkg::geo_rsp_type rsp_data
);

   logic err_status;
   logic zero_count_status;

   assign err_status        = (rsp_data.status != fat_geo_pkg::ST_OK);
   assign zero_count_status = (rsp_data.status == fat_geo_pkg::ST_FAT_ZERO) ||
                              (rsp_data.status == fat_geo_pkg::ST_DIV_ZERO);

   // a stalled request transaction holds
   `FGEO_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_data), "request changed while stalled")

   // a stalled result transaction holds
   `FGEO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // failed volumes carry no offsets
   `FGEO_ASSERT_SAME(a_err_offsets, clock, reset, rsp_valid && err_status, rsp_data.fat_offset == 32'd0 && rsp_data.root_offset == 32'd0 && rsp_data.data_offset == 32'd0, "offsets set on error")

   // zero fat size and zero divisor report no cluster count
   `FGEO_ASSERT_SAME(a_err_count, clock, reset, rsp_valid && zero_count_status, rsp_data.cluster_count == 32'd0, "cluster count set on early error")

   // a good volume has a cluster count in the fat16 range
   `FGEO_ASSERT_SAME(a_ok_range, clock, reset, rsp_valid && !err_status, rsp_data.cluster_count >= fat_geo_pkg::MIN_CLUSTERS && rsp_data.cluster_count <= fat_geo_pkg::MAX_CLUSTERS, "ok status with count out of range")

endmodule

bind fat16_volume_geometry_core fat_geo_chk u_fat_geo_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
